### src/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants for the cylinder bounding box pipeline.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CFG_W      = 31;
  localparam int unsigned IDX_W      = 2;

  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] RADIUS_RST = 31'd65536;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 31'd65536;

  typedef struct packed {
    logic signed [15:0] rot_a;
    logic signed [15:0] rot_b;
    logic signed [15:0] rot_c;
    logic        [15:0] scale_x;
    logic        [15:0] scale_y;
    logic        [15:0] scale_z;
    logic signed [31:0] center;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] box_min;
    logic signed [31:0] box_max;
  } out_item_t;

  // carried alongside the square root
  typedef struct packed {
    logic        [30:0] pz;
    logic signed [31:0] ctr;
  } side_t;

endpackage

### src/cbb_front.sv
// ----------------------------------------------------------------------------
// cbb_front
// Magnitudes, scaled rotation products, squares and their sum.
// ----------------------------------------------------------------------------
module cbb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  cbb_pkg::in_item_t in_item,
  output logic              out_vld,
  output logic [62:0]       out_sumsq,
  output cbb_pkg::side_t    out_side
);

  logic [3:0]         vld_r;
  logic [16:0]        ra_r, rb_r, rc_r;
  logic [15:0]        sx_r, sy_r, sz_r;
  logic signed [31:0] c1_r, c2_r, c3_r, c4_r;
  logic [30:0]        px_r, py_r, pz2_r, pz3_r, pz4_r;
  logic [61:0]        qx_r, qy_r;
  logic [62:0]        sum_r;

  function automatic logic [16:0] mag(input logic signed [15:0] x);
    logic signed [16:0] w;
    w = {x[15], x};
    return w[16] ? 17'(-w) : 17'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ra_r  <= mag(in_item.rot_a);
    rb_r  <= mag(in_item.rot_b);
    rc_r  <= mag(in_item.rot_c);
    sx_r  <= in_item.scale_x;
    sy_r  <= in_item.scale_y;
    sz_r  <= in_item.scale_z;
    c1_r  <= in_item.center;
    px_r  <= 31'({17'd0, sx_r} * {16'd0, ra_r});
    py_r  <= 31'({17'd0, sy_r} * {16'd0, rb_r});
    pz2_r <= 31'({17'd0, sz_r} * {16'd0, rc_r});
    c2_r  <= c1_r;
    qx_r  <= {31'd0, px_r} * {31'd0, px_r};
    qy_r  <= {31'd0, py_r} * {31'd0, py_r};
    pz3_r <= pz2_r;
    c3_r  <= c2_r;
    sum_r <= {1'b0, qx_r} + {1'b0, qy_r};
    pz4_r <= pz3_r;
    c4_r  <= c3_r;
  end

  assign out_vld      = vld_r[3];
  assign out_sumsq    = sum_r;
  assign out_side.pz  = pz4_r;
  assign out_side.ctr = c4_r;

endmodule

### src/cbb_sqrt_stage.sv
// ----------------------------------------------------------------------------
// cbb_sqrt_stage
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module cbb_sqrt_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  logic [63:0]    in_rem,
  input  logic [63:0]    in_root,
  input  cbb_pkg::side_t in_side,
  output logic           out_vld,
  output logic [63:0]    out_rem,
  output logic [63:0]    out_root,
  output cbb_pkg::side_t out_side
);

  localparam logic [63:0] BIT = 64'd1 << SHIFT;

  logic           vld_r;
  logic [63:0]    rem_r, root_r;
  cbb_pkg::side_t side_r;
  logic [63:0]    trial;

  assign trial = in_root + BIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= in_side;
    if (in_rem >= trial) begin
      rem_r  <= in_rem - trial;
      root_r <= (in_root >> 1) + BIT;
    end else begin
      rem_r  <= in_rem;
      root_r <= in_root >> 1;
    end
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

### src/cbb_back.sv
// ----------------------------------------------------------------------------
// cbb_back
// Scale by radius and height, form the half extent, saturate the bounds.
// ----------------------------------------------------------------------------
module cbb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [31:0]         in_root,
  input  cbb_pkg::side_t      in_side,
  input  logic [30:0]         radius,
  input  logic [30:0]         cyl_height,
  output logic                out_vld,
  output cbb_pkg::out_item_t  out_item
);

  localparam logic signed [43:0] SMAX = 44'sd2147483647;
  localparam logic signed [43:0] SMIN = -44'sd2147483648;

  logic [1:0]         vld_r;
  logic [62:0]        sprod_r, cprod_r;
  logic signed [31:0] ctr_r;
  cbb_pkg::out_item_t res_r;
  logic [42:0]        half;
  logic signed [43:0] lo, hi;

  function automatic logic [31:0] sat(input logic signed [43:0] v);
    if (v > SMAX) return SMAX[31:0];
    if (v < SMIN) return SMIN[31:0];
    return v[31:0];
  endfunction

  assign half = 43'(sprod_r >> 22) + 43'(cprod_r >> 23);
  assign lo   = 44'(ctr_r) - $signed({1'b0, half});
  assign hi   = 44'(ctr_r) + $signed({1'b0, half});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    sprod_r       <= {32'd0, radius} * {31'd0, in_root};
    cprod_r       <= {32'd0, cyl_height} * {32'd0, in_side.pz};
    ctr_r         <= in_side.ctr;
    res_r.box_min <= sat(lo);
    res_r.box_max <= sat(hi);
  end

  assign out_vld  = vld_r[1];
  assign out_item = res_r;

endmodule

### src/cylinder_bounding_box.sv
// ----------------------------------------------------------------------------
// cylinder_bounding_box
// One world axis of the bounding box of a scaled, rotated, translated
// z-aligned cylinder: center -/+ (radius*sqrt((sx*a)^2+(sy*b)^2) + h/2*|sz*c|).
// ----------------------------------------------------------------------------
// A transaction is taken at every cycle with start high; busy is always low.
// Each result appears on out_data with out_valid high for one cycle, after
// 4 product/square stages, 32 square-root stages (one result bit each) and
// 2 scale/saturate stages. One transaction per cycle sustained. Results
// cannot be held off. Write radius and cyl_height only while no transaction
// is in flight.
module cylinder_bounding_box (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  cbb_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output cbb_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [cbb_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [cbb_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned N = cbb_pkg::SQRT_STEPS;

  logic [cbb_pkg::CFG_W-1:0] radius_r, height_r;
  logic                      vld    [N+1];
  logic [63:0]               rem    [N+1];
  logic [63:0]               root   [N+1];
  cbb_pkg::side_t            side   [N+1];
  logic [62:0]               sumsq;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= cbb_pkg::RADIUS_RST;
      height_r <= cbb_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cbb_pkg::REG_RADIUS: radius_r <= cfg_wdata;
        cbb_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cbb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start),
    .in_item   (in_data),
    .out_vld   (vld[0]),
    .out_sumsq (sumsq),
    .out_side  (side[0])
  );

  assign rem[0]  = {1'b0, sumsq};
  assign root[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_sqrt
    cbb_sqrt_stage #(.SHIFT(2 * (N - 1 - j))) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld[j]),
      .in_rem   (rem[j]),
      .in_root  (root[j]),
      .in_side  (side[j]),
      .out_vld  (vld[j+1]),
      .out_rem  (rem[j+1]),
      .out_root (root[j+1]),
      .out_side (side[j+1])
    );
  end

  cbb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (vld[N]),
    .in_root    (root[N][31:0]),
    .in_side    (side[N]),
    .radius     (radius_r),
    .cyl_height (height_r),
    .out_vld    (out_valid),
    .out_item   (out_data)
  );

endmodule
